// File: design/mfpr_pkg.sv
// shared constants and helpers for the meter frame power rewriter
package mfpr_pkg;

    localparam int FRAME_LEN  = 8;
    localparam int IDX_W      = $clog2(FRAME_LEN);
    localparam int PWR_HI_POS = 4;
    localparam int PWR_LO_POS = 5;
    localparam int CHK_POS    = 7;
    localparam int CHK_BASE   = 264;

    localparam logic [15:0] OFFSET_RESET = 16'd350;
    localparam logic [15:0] ERR_MAX      = 16'hFFFF;
    localparam logic [7:0]  BYTE_MASK    = 8'hFF;

    localparam int          PADDR_W  = 3;
    localparam logic        REG_POWER_OFFSET = 1'b0;

    typedef logic [7:0] byte_t;

    function automatic byte_t frame_checksum(input byte_t hi, input byte_t lo);
        byte_t base;
        base = byte_t'(CHK_BASE);
        return (base - hi - lo) & BYTE_MASK;
    endfunction

endpackage

// File: design/meter_frame_power_rewriter.sv
// meter frame collector with checksum test, power offset and frame re-emission
// latency: the eighth byte of a frame is loaded into the output buffer at its accept
//   edge; its first beat is valid the next cycle, then one per cycle unless stalled
// throughput: one byte in per cycle; a frame's eight output beats drain while the
//   next frame collects, so input stalls only if the output side stalls
// reset: byte position, error run and output buffer state clear; offset returns to 350
module meter_frame_power_rewriter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   rx_byte,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [7:0]                   out_byte,
    output logic                         frame_last,
    output logic                         checksum_good,
    output logic [15:0]                  bad_frames,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mfpr_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam logic [mfpr_pkg::IDX_W-1:0] LAST_IDX = mfpr_pkg::IDX_W'(mfpr_pkg::FRAME_LEN - 1);

    mfpr_pkg::byte_t                collect_reg [mfpr_pkg::FRAME_LEN-1];
    logic [mfpr_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic [15:0]                    err_reg, err_next;
    logic [15:0]                    offset_reg;

    mfpr_pkg::byte_t                obuf_reg  [mfpr_pkg::FRAME_LEN];
    mfpr_pkg::byte_t                obuf_load [mfpr_pkg::FRAME_LEN];
    logic                           busy_reg, busy_next;
    logic [mfpr_pkg::IDX_W-1:0]     opos_reg, opos_next;
    logic                           good_reg, good_next;

    logic                           in_beat, out_beat, frame_end, buf_free, load;
    logic                           good;
    logic [15:0]                    pwr_sum;
    mfpr_pkg::byte_t                new_chk;

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == mfpr_pkg::REG_POWER_OFFSET) ? {16'd0, offset_reg} : 32'd0;

    assign out_beat  = out_valid && out_ready;
    assign buf_free  = !busy_reg || (out_beat && opos_reg == LAST_IDX);
    assign in_ready  = (idx_reg != LAST_IDX) || buf_free;
    assign in_beat   = in_valid && in_ready;
    assign frame_end = in_beat && idx_reg == LAST_IDX;
    assign load      = frame_end;

    // frame check uses the stored power bytes and the arriving checksum byte
    assign good    = rx_byte == mfpr_pkg::frame_checksum(collect_reg[mfpr_pkg::PWR_HI_POS],
                                                         collect_reg[mfpr_pkg::PWR_LO_POS]);
    assign pwr_sum = {collect_reg[mfpr_pkg::PWR_HI_POS], collect_reg[mfpr_pkg::PWR_LO_POS]}
                     + offset_reg;
    assign new_chk = mfpr_pkg::frame_checksum(pwr_sum[15:8], pwr_sum[7:0]);

    always_comb
    begin
        for (int k = 0; k < mfpr_pkg::FRAME_LEN - 1; k++)
        begin
            obuf_load[k] = collect_reg[k];
        end
        obuf_load[mfpr_pkg::CHK_POS] = rx_byte;
        if (good)
        begin
            obuf_load[mfpr_pkg::PWR_HI_POS] = pwr_sum[15:8];
            obuf_load[mfpr_pkg::PWR_LO_POS] = pwr_sum[7:0];
            obuf_load[mfpr_pkg::CHK_POS]    = new_chk;
        end
    end

    always_comb
    begin
        idx_next  = idx_reg;
        err_next  = err_reg;
        busy_next = busy_reg;
        opos_next = opos_reg;
        good_next = good_reg;
        if (in_beat)
        begin
            idx_next = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
        end
        if (out_beat)
        begin
            opos_next = opos_reg + 1'b1;
            if (opos_reg == LAST_IDX)
            begin
                busy_next = 1'b0;
            end
        end
        if (load)
        begin
            busy_next = 1'b1;
            opos_next = '0;
            good_next = good;
            if (good)
            begin
                err_next = '0;
            end
            else if (err_reg != mfpr_pkg::ERR_MAX)
            begin
                err_next = err_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            err_reg    <= '0;
            busy_reg   <= 1'b0;
            opos_reg   <= '0;
            good_reg   <= 1'b0;
            offset_reg <= mfpr_pkg::OFFSET_RESET;
        end
        else
        begin
            idx_reg  <= idx_next;
            err_reg  <= err_next;
            busy_reg <= busy_next;
            opos_reg <= opos_next;
            good_reg <= good_next;
            if (psel && penable && pwrite && pready
                && paddr[2] == mfpr_pkg::REG_POWER_OFFSET)
            begin
                offset_reg <= pwdata[15:0];
            end
        end
    end

    // payload: collection bytes and the output shift line
    always_ff @(posedge clk)
    begin
        if (in_beat && idx_reg != LAST_IDX)
        begin
            collect_reg[idx_reg] <= rx_byte;
        end
        if (load)
        begin
            obuf_reg <= obuf_load;
        end
        else if (out_beat)
        begin
            for (int k = 0; k < mfpr_pkg::FRAME_LEN - 1; k++)
            begin
                obuf_reg[k] <= obuf_reg[k + 1];
            end
        end
    end

    assign out_valid     = busy_reg;
    assign out_byte      = obuf_reg[0];
    assign frame_last    = opos_reg == LAST_IDX;
    assign checksum_good = good_reg;
    assign bad_frames    = err_reg;

endmodule

// File: design/mfpr_checker.sv
// port-level checks for the meter frame power rewriter, bound to the top level
module mfpr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  out_byte,
    input logic        frame_last,
    input logic        checksum_good,
    input logic [15:0] bad_frames
);

    // a stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(frame_last))
        else $error("stalled output beat changed");

    // frame status stays fixed within a frame and the next beat follows at once
    a_frame_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !frame_last
        |=> out_valid && $stable(checksum_good) && $stable(bad_frames))
        else $error("frame status changed mid-frame");

    a_good_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && checksum_good |-> bad_frames == 16'd0)
        else $error("good frame with nonzero error run");

    a_bad_counts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !checksum_good |-> bad_frames != 16'd0)
        else $error("bad frame with zero error run");

    // once reset has been seen at an edge the output stays idle while it lasts
    a_reset_idle: assert property (@(posedge clk)
        !rst_n ##1 !rst_n |-> !out_valid)
        else $error("output valid during reset");

endmodule

bind meter_frame_power_rewriter mfpr_checker u_mfpr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .frame_last    (frame_last),
    .checksum_good (checksum_good),
    .bad_frames    (bad_frames)
);
